[sv/aht_pkg.sv]
// Shared types and constants for the averaged hysteresis thermostat.
// Used by the register block, the control unit and the top level.
package aht_pkg;

	localparam int SUM_W    = 12;
	localparam int TEMP_W   = 8;
	localparam int SETP_W   = 7;
	localparam int BAND_W   = 5;
	localparam int STEP_W   = 5;
	localparam int TICKS_W  = 6;
	localparam int CFG_AW   = 5;
	localparam int CFG_DW   = 32;

	localparam logic [BAND_W-1:0]  BAND_RESET   = 5'd5;
	localparam logic [STEP_W-1:0]  STEP_RESET   = 5'd5;
	localparam logic [SETP_W-1:0]  LOW_RESET    = 7'd35;
	localparam logic [SETP_W-1:0]  HIGH_RESET   = 7'd75;
	localparam logic [TICKS_W-1:0] COMMIT_RESET = 6'd50;
	localparam logic [SETP_W-1:0]  TARGET_RESET = 7'd60;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_UP     = 2'd1,
		MODE_DOWN   = 2'd2,
		MODE_TICK   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_BAND   = 3'd0,
		REG_STEP   = 3'd1,
		REG_LOW    = 3'd2,
		REG_HIGH   = 3'd3,
		REG_COMMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [BAND_W-1:0]  band;
		logic [STEP_W-1:0]  step;
		logic [SETP_W-1:0]  low_limit;
		logic [SETP_W-1:0]  high_limit;
		logic [TICKS_W-1:0] commit_ticks;
	} cfg_t;

	typedef struct packed {
		logic              heater_on;
		logic              editing;
		logic [SETP_W-1:0] pending;
		logic [SETP_W-1:0] setpoint;
	} ctrl_res_t;

endpackage

[sv/aht_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the sample window; no dependencies.
module aht_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/aht_cfg.sv]
// APB register block: band, step, setpoint limits and commit tick count.
// Depends on aht_pkg for the register indexes, reset values and cfg_t.
module aht_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [aht_pkg::CFG_AW-1:0] paddr,
	input  logic [aht_pkg::CFG_DW-1:0] pwdata,
	output logic [aht_pkg::CFG_DW-1:0] prdata,
	output logic                      pready,
	output aht_pkg::cfg_t             cfg
);

	aht_pkg::cfg_t    cfg_q;
	aht_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = aht_pkg::reg_idx_t'(paddr[aht_pkg::CFG_AW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band         <= aht_pkg::BAND_RESET;
			cfg_q.step         <= aht_pkg::STEP_RESET;
			cfg_q.low_limit    <= aht_pkg::LOW_RESET;
			cfg_q.high_limit   <= aht_pkg::HIGH_RESET;
			cfg_q.commit_ticks <= aht_pkg::COMMIT_RESET;
		end else if (wr_en) begin
			case (idx)
				aht_pkg::REG_BAND:   cfg_q.band         <= pwdata[aht_pkg::BAND_W-1:0];
				aht_pkg::REG_STEP:   cfg_q.step         <= pwdata[aht_pkg::STEP_W-1:0];
				aht_pkg::REG_LOW:    cfg_q.low_limit    <= pwdata[aht_pkg::SETP_W-1:0];
				aht_pkg::REG_HIGH:   cfg_q.high_limit   <= pwdata[aht_pkg::SETP_W-1:0];
				aht_pkg::REG_COMMIT: cfg_q.commit_ticks <= pwdata[aht_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			aht_pkg::REG_BAND:   prdata = aht_pkg::CFG_DW'(cfg_q.band);
			aht_pkg::REG_STEP:   prdata = aht_pkg::CFG_DW'(cfg_q.step);
			aht_pkg::REG_LOW:    prdata = aht_pkg::CFG_DW'(cfg_q.low_limit);
			aht_pkg::REG_HIGH:   prdata = aht_pkg::CFG_DW'(cfg_q.high_limit);
			aht_pkg::REG_COMMIT: prdata = aht_pkg::CFG_DW'(cfg_q.commit_ticks);
			default:             prdata = '0;
		endcase
	end

endmodule

[sv/aht_ctrl.sv]
// Setpoint editing (press, tick, commit) and the bang-bang regulator.
// Depends on aht_pkg for mode codes, cfg_t and ctrl_res_t.
module aht_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  aht_pkg::cfg_t               cfg,
	input  logic                        upd,
	input  aht_pkg::mode_t              mode,
	input  logic [aht_pkg::TEMP_W-1:0]  avg,
	output aht_pkg::ctrl_res_t          res
);

	localparam logic [aht_pkg::TICKS_W-1:0] IDLE_MAX = '1;

	typedef enum logic [1:0] {
		ST_INIT = 2'd0,
		ST_HEAT = 2'd1,
		ST_COOL = 2'd2
	} reg_state_t;

	reg_state_t                     state_q, state_nx;
	logic [aht_pkg::SETP_W-1:0]     target_q, target_nx;
	logic [aht_pkg::SETP_W-1:0]     pend_q, pend_nx;
	logic                           edit_q, edit_nx;
	logic [aht_pkg::TICKS_W-1:0]    idle_q, idle_nx, idle_inc;
	logic [aht_pkg::SETP_W:0]       up_sum;
	logic [aht_pkg::SETP_W:0]       dn_floor;
	logic [aht_pkg::TEMP_W-1:0]     hi_th;
	logic                           at_hi, at_lo;

	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
	assign up_sum   = {1'b0, pend_q} + {3'b0, cfg.step};
	assign dn_floor = {1'b0, cfg.low_limit} + {3'b0, cfg.step};

	always_comb begin
		target_nx = target_q;
		pend_nx   = pend_q;
		edit_nx   = edit_q;
		idle_nx   = idle_q;
		case (mode)
			aht_pkg::MODE_UP: begin
				idle_nx = '0;
				if (!edit_q) begin
					edit_nx = 1'b1;
				end else if (pend_q < cfg.high_limit) begin
					pend_nx = (up_sum > {1'b0, cfg.high_limit}) ? cfg.high_limit
						: up_sum[aht_pkg::SETP_W-1:0];
				end
			end
			aht_pkg::MODE_DOWN: begin
				idle_nx = '0;
				if (!edit_q) begin
					edit_nx = 1'b1;
				end else if (pend_q > cfg.low_limit) begin
					// floor at the low limit, which also covers going below zero
					pend_nx = ({1'b0, pend_q} < dn_floor) ? cfg.low_limit
						: pend_q - {2'b0, cfg.step};
				end
			end
			aht_pkg::MODE_TICK: begin
				idle_nx = idle_inc;
				if (edit_q && idle_inc >= cfg.commit_ticks) begin
					target_nx = pend_q;
					edit_nx   = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// thresholds against the setpoint after this item's update
	assign hi_th = {1'b0, target_nx} + {3'b0, cfg.band};
	assign at_hi = avg >= hi_th;
	assign at_lo = ({1'b0, avg} + {4'b0, cfg.band}) <= {2'b0, target_nx};

	always_comb begin
		case (state_q)
			ST_HEAT: state_nx = at_hi ? ST_COOL : ST_HEAT;
			ST_COOL: state_nx = at_lo ? ST_HEAT : ST_COOL;
			default: state_nx = at_hi ? ST_COOL : ST_HEAT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			target_q <= aht_pkg::TARGET_RESET;
			pend_q   <= aht_pkg::TARGET_RESET;
			edit_q   <= 1'b0;
			idle_q   <= '0;
		end else if (upd) begin
			state_q  <= state_nx;
			target_q <= target_nx;
			pend_q   <= pend_nx;
			edit_q   <= edit_nx;
			idle_q   <= idle_nx;
		end
	end

	assign res.heater_on = (state_nx == ST_HEAT);
	assign res.editing   = edit_nx;
	assign res.pending   = pend_nx;
	assign res.setpoint  = target_nx;

endmodule

[sv/averaged_hysteresis_thermostat_core.sv]
// Top level: input stage, sample window in RAM with running sum, output register.
// Depends on aht_pkg, aht_ram, aht_cfg and aht_ctrl.
//
//  channel  | role    | payload
//  ---------+---------+----------------------------------------------------------
//  s_*      | in      | tuser: mode; tdata: temperature
//  m_*      | out     | tuser: editing; tdata: heater_on, average, shown_value,
//           |         |        setpoint
//  APB      | config  | band, step, low_limit, high_limit, commit_ticks
//
// One item per cycle sustained while the output is not stalled.
// The input stage reads the window slot in RAM; the second updates the sum,
// average, setpoint and regulator and loads the output register.
// Reset clears the window through per-slot valid bits, so items are taken
// from the first cycle after reset. A stalled output holds the second stage,
// and the input side keeps taking items while the output stage can drain.
module averaged_hysteresis_thermostat_core #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] temperature
	input  logic [1:0]                 s_tuser,   // [1:0] mode
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [23:0]                m_tdata,   // [0] heater_on, [8:1] average,
	                                              // [16:9] shown_value, [23:17] setpoint
	output logic                       m_tuser,   // [0] editing
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [aht_pkg::CFG_AW-1:0] paddr,
	input  logic [aht_pkg::CFG_DW-1:0] pwdata,
	output logic [aht_pkg::CFG_DW-1:0] prdata,
	output logic                       pready
);

	localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
	localparam int DIV_SHIFT = 17;
	localparam int MUL_W     = 18;
	localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
	localparam int PROD_W    = aht_pkg::SUM_W + MUL_W;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

	aht_pkg::cfg_t      cfg;
	aht_pkg::ctrl_res_t res;

	// input stage
	logic                        v_s1;
	aht_pkg::mode_t              mode_s1;
	logic [aht_pkg::TEMP_W-1:0]  temp_s1;
	logic [SLOT_W-1:0]           slot_s1;
	logic                        acc, adv_s1, smp_s1;
	aht_pkg::mode_t              in_mode;

	// window state
	logic [SLOT_W-1:0]           slot_q;
	logic                        vld_q [WINDOW_DEPTH];
	logic [aht_pkg::SUM_W-1:0]   sum_q, sum_nx;
	logic [aht_pkg::TEMP_W-1:0]  last_q, last_nx;
	logic [aht_pkg::TEMP_W-1:0]  rdata, old_val, avg;
	logic [PROD_W-1:0]           prod;

	// output register
	logic                        ov_q;
	logic [23:0]                 odata_q;
	logic                        ouser_q;
	logic [aht_pkg::TEMP_W-1:0]  shown;

	aht_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_mode  = aht_pkg::mode_t'(s_tuser);
	assign adv_s1   = v_s1 && (!ov_q || m_tready);
	assign s_tready = !v_s1 || adv_s1;
	assign acc      = s_tvalid && s_tready;
	assign smp_s1   = (mode_s1 == aht_pkg::MODE_SAMPLE);

	aht_ram #(
		.DEPTH (WINDOW_DEPTH),
		.WIDTH (aht_pkg::TEMP_W)
	) u_window (
		.clk   (clk),
		.we    (adv_s1 && smp_s1),
		.waddr (slot_s1),
		.wdata (temp_s1),
		.re    (acc && (in_mode == aht_pkg::MODE_SAMPLE)),
		.raddr (slot_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			slot_q <= '0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			// advance the write slot at transfer so back-to-back samples never collide
			if (acc && in_mode == aht_pkg::MODE_SAMPLE) begin
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= in_mode;
			temp_s1 <= s_tdata;
			slot_s1 <= slot_q;
		end
	end

	// a slot never written since reset reads as zero
	assign old_val = vld_q[slot_s1] ? rdata : '0;
	assign sum_nx  = smp_s1 ? sum_q - {4'b0, old_val} + {4'b0, temp_s1} : sum_q;
	assign last_nx = smp_s1 ? temp_s1 : last_q;

	// divide by the window depth through a reciprocal multiply
	assign prod = {{MUL_W{1'b0}}, sum_nx} * {{aht_pkg::SUM_W{1'b0}}, MUL_W'(DIV_MUL)};
	assign avg  = prod[DIV_SHIFT+aht_pkg::TEMP_W-1:DIV_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			last_q <= '0;
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv_s1) begin
			sum_q  <= sum_nx;
			last_q <= last_nx;
			if (smp_s1) begin
				vld_q[slot_s1] <= 1'b1;
			end
		end
	end

	aht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.upd    (adv_s1),
		.mode   (mode_s1),
		.avg    (avg),
		.res    (res)
	);

	assign shown = res.editing ? {1'b0, res.pending} : last_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv_s1) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			odata_q <= {res.setpoint, shown, avg, res.heater_on};
			ouser_q <= res.editing;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;

endmodule

[sv/aht_checker.sv]
// Port-level checks for the thermostat core, attached by bind.
// Depends only on the handshake and result ports of the core.
module aht_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [23:0]                m_tdata,
	input logic                       m_tuser,
	input logic                       pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a transfer into an empty output side passes the input stage, then shows up
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
		else $error("result missing two cycles after transfer");

	// no result without an earlier transfer in
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result appeared without a transfer");

	// register writes never wait
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind averaged_hysteresis_thermostat_core aht_checker u_aht_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready)
);

[sim/averaged_hysteresis_thermostat_core_tb.sv]
// Testbench for averaged_hysteresis_thermostat_core: a self-checking run that
// predicts every result from its own thermostat model and compares per field.
// Depends on aht_pkg and the core RTL.
`timescale 1ns / 100ps

module averaged_hysteresis_thermostat_core_tb;

	localparam int WINDOW_DEPTH = 10;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 83;
	localparam int HOLD_CYCLES = 120;

	class thermo_scoreboard;
		typedef enum logic [1:0] {HEAT_START, HEAT_ON, HEAT_OFF} regulator_t;

		typedef struct packed {
			logic       heater_on;
			logic [7:0] average;
			logic       editing;
			logic [7:0] shown_value;
			logic [6:0] setpoint;
		} reading_t;

		logic [4:0] band;
		logic [4:0] step;
		logic [6:0] low_lim;
		logic [6:0] high_lim;
		logic [5:0] commit;

		logic [7:0] samples[WINDOW_DEPTH];
		logic [11:0] sum;
		int slot;
		regulator_t regulator;
		logic [6:0] target;
		logic [6:0] pending;
		logic edit_mode;
		logic [5:0] idle;
		logic [7:0] last_temp;

		reading_t expected_readings[$];
		int errors;

		function new();
			band = aht_pkg::BAND_RESET;
			step = aht_pkg::STEP_RESET;
			low_lim = aht_pkg::LOW_RESET;
			high_lim = aht_pkg::HIGH_RESET;
			commit = aht_pkg::COMMIT_RESET;
			foreach (samples[i]) samples[i] = '0;
			sum = '0;
			slot = 0;
			regulator = HEAT_START;
			target = aht_pkg::TARGET_RESET;
			pending = aht_pkg::TARGET_RESET;
			edit_mode = 1'b0;
			idle = '0;
			last_temp = '0;
			errors = 0;
		endfunction

		function void set_reg(aht_pkg::reg_idx_t idx, logic [31:0] value);
			case (idx)
				aht_pkg::REG_BAND:   band = value[4:0];
				aht_pkg::REG_STEP:   step = value[4:0];
				aht_pkg::REG_LOW:    low_lim = value[6:0];
				aht_pkg::REG_HIGH:   high_lim = value[6:0];
				aht_pkg::REG_COMMIT: commit = value[5:0];
				default: ;
			endcase
		endfunction

		function void note_input(aht_pkg::mode_t mode, logic [7:0] temp);
			int hi;
			int lo;
			int v;
			logic [7:0] avg;
			reading_t r;
			case (mode)
				aht_pkg::MODE_SAMPLE: begin
					sum = sum - 12'(samples[slot]) + 12'(temp);
					samples[slot] = temp;
					last_temp = temp;
					slot = (slot == WINDOW_DEPTH - 1) ? 0 : slot + 1;
				end
				aht_pkg::MODE_UP, aht_pkg::MODE_DOWN: begin
					idle = '0;
					// the first press only opens edit mode
					if (!edit_mode) begin
						edit_mode = 1'b1;
					end else if (mode == aht_pkg::MODE_UP) begin
						if (pending < high_lim) begin
							v = int'(pending) + int'(step);
							if (v > int'(high_lim)) pending = high_lim;
							else pending = v[6:0];
						end
					end else begin
						if (pending > low_lim) begin
							v = int'(pending) - int'(step);
							if (v < int'(low_lim)) pending = low_lim;
							else pending = v[6:0];
						end
					end
				end
				default: begin
					if (idle != 6'd63) idle = idle + 6'd1;
					if (edit_mode && idle >= commit) begin
						target = pending;
						edit_mode = 1'b0;
					end
				end
			endcase

			avg = 8'(int'(sum) / WINDOW_DEPTH);
			hi = int'(target) + int'(band);
			lo = int'(target) - int'(band);
			case (regulator)
				HEAT_ON:  if (int'(avg) >= hi) regulator = HEAT_OFF;
				HEAT_OFF: if (int'(avg) <= lo) regulator = HEAT_ON;
				default:  regulator = (int'(avg) >= hi) ? HEAT_OFF : HEAT_ON;
			endcase

			r.heater_on = (regulator == HEAT_ON);
			r.average = avg;
			r.editing = edit_mode;
			r.shown_value = edit_mode ? {1'b0, pending} : last_temp;
			r.setpoint = target;
			expected_readings.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(logic [23:0] data, logic editing);
			reading_t want;
			if (expected_readings.size() == 0) begin
				report($sformatf("result with nothing expected, tdata %h", data));
			end else begin
				want = expected_readings.pop_front();
				if (data[0] !== want.heater_on)
					report($sformatf("heater_on %b, want %b", data[0], want.heater_on));
				if (data[8:1] !== want.average)
					report($sformatf("average %0d, want %0d", data[8:1], want.average));
				if (editing !== want.editing)
					report($sformatf("editing %b, want %b", editing, want.editing));
				if (data[16:9] !== want.shown_value)
					report($sformatf("shown_value %0d, want %0d", data[16:9],
						want.shown_value));
				if (data[23:17] !== want.setpoint)
					report($sformatf("setpoint %0d, want %0d", data[23:17], want.setpoint));
			end
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [7:0]                 s_tdata;   // [7:0] temperature
	logic [1:0]                 s_tuser;   // [1:0] mode
	logic                       m_tvalid;
	logic                       m_tready;
	logic [23:0]                m_tdata;   // [0] heater_on, [8:1] average,
	                                       // [16:9] shown_value, [23:17] setpoint
	logic                       m_tuser;   // [0] editing
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [aht_pkg::CFG_AW-1:0] paddr;
	logic [aht_pkg::CFG_DW-1:0] pwdata;
	logic [aht_pkg::CFG_DW-1:0] prdata;
	logic                       pready;

	thermo_scoreboard sb = new();

	logic calm = 1'b0;
	logic hold_request = 1'b0;

	averaged_hysteresis_thermostat_core #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (calm || $urandom_range(0, 99) < 80) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end
		end
	end

	task automatic apb_write(aht_pkg::reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one item, hold until the transfer, then idle a random gap.
	task automatic send(aht_pkg::mode_t mode, logic [7:0] temp);
		int gap;
		int r;
		s_tuser <= mode;
		s_tdata <= temp;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(mode, temp);
		@(negedge clk);
		r = $urandom_range(0, 99);
		if (calm || r < 70) gap = 0;
		else if (r < 95) gap = $urandom_range(1, 3);
		else gap = $urandom_range(8, 30);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.expected_readings.size() != 0);
	endtask

	task automatic configure(logic [4:0] band, logic [4:0] step, logic [6:0] low_lim,
		logic [6:0] high_lim, logic [5:0] commit);
		apb_write(aht_pkg::REG_BAND, 32'(band));
		apb_write(aht_pkg::REG_STEP, 32'(step));
		apb_write(aht_pkg::REG_LOW, 32'(low_lim));
		apb_write(aht_pkg::REG_HIGH, 32'(high_lim));
		apb_write(aht_pkg::REG_COMMIT, 32'(commit));
	endtask

	// Mostly well-formed bursts: samples near the setpoint, press runs, tick runs
	// of up to four past the commit count; a little noise on top.
	task automatic run_random(int count);
		int sent;
		int len;
		int kind;
		int span;
		int v;
		aht_pkg::mode_t dir;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				len = $urandom_range(1, 12);
				span = int'(sb.band) + 20;
				repeat (len) begin
					if ($urandom_range(0, 3) != 0) begin
						v = int'(sb.target) + int'($urandom_range(0, 2 * span)) - span;
						if (v < 0) v = 0;
						if (v > 255) v = 255;
					end else begin
						v = $urandom_range(0, 255);
					end
					send(aht_pkg::MODE_SAMPLE, v[7:0]);
				end
			end else if (kind < 65) begin
				len = $urandom_range(1, 6);
				dir = $urandom_range(0, 1) ? aht_pkg::MODE_UP : aht_pkg::MODE_DOWN;
				repeat (len) begin
					if ($urandom_range(0, 9) < 7) send(dir, 8'($urandom));
					else if (dir == aht_pkg::MODE_UP) send(aht_pkg::MODE_DOWN, 8'($urandom));
					else send(aht_pkg::MODE_UP, 8'($urandom));
				end
			end else if (kind < 90) begin
				len = $urandom_range(1, int'(sb.commit) + 4);
				repeat (len) send(aht_pkg::MODE_TICK, 8'($urandom));
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) send(aht_pkg::mode_t'($urandom_range(0, 3)), 8'($urandom));
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = aht_pkg::MODE_SAMPLE;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes, first press opening edit mode, saturation at
		// both limits, a sample while editing, ticks below the commit count.
		send(aht_pkg::MODE_SAMPLE, 8'd0);
		send(aht_pkg::MODE_SAMPLE, 8'd255);
		send(aht_pkg::MODE_SAMPLE, 8'd255);
		send(aht_pkg::MODE_SAMPLE, 8'd255);
		send(aht_pkg::MODE_SAMPLE, 8'd200);
		send(aht_pkg::MODE_TICK, 8'd255);
		send(aht_pkg::MODE_UP, 8'd0);
		repeat (4) send(aht_pkg::MODE_UP, 8'd170);
		repeat (9) send(aht_pkg::MODE_DOWN, 8'd85);
		send(aht_pkg::MODE_SAMPLE, 8'd7);
		send(aht_pkg::MODE_TICK, 8'd0);
		send(aht_pkg::MODE_UP, 8'd255);
		send(aht_pkg::MODE_TICK, 8'd1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				case (p)
					1: configure(5'd0, 5'd1, 7'd0, 7'd127, 6'd1);
					2: configure(5'd20, 5'd20, 7'd100, 7'd127, 6'd63);
					// inverted limits, commit on the first tick
					3: configure(5'd3, 5'd7, 7'd80, 7'd40, 6'd0);
					default: configure(5'($urandom_range(0, 20)), 5'($urandom_range(1, 20)),
						7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
						6'($urandom_range(1, 63)));
				endcase
			end
			calm = (p == 4);
			if (p == 1) hold_request = 1'b1;
			run_random(PHASE_ITEMS);
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.expected_readings.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
